// File: rtl/itkf_pkg.sv
// Shared constants and a lookup function for the IMU tilt Kalman fusion unit.
`default_nettype none
package itkf_pkg;

  localparam int unsigned AtanSteps = 24;
  localparam int unsigned SqrtSteps = 24;

  localparam logic [31:0] VarReset = 32'h0400_0000;
  localparam logic [31:0] ProcVar = 32'd4295;
  localparam logic [32:0] MeasVar = 33'd150994944;

  // rate step: (d * 2^15 + 8187) / 16375 equals the rounded d * 262144 / 131000
  localparam logic [13:0] RateDiv = 14'd16375;
  localparam logic [23:0] RateRecip = 24'd1049152;
  localparam logic [33:0] RateBias = 34'd8187;
  // degrees: ((z * 5625 + 804352) >> 10) / 1571 equals the rounded z * 90000 / 25739264
  localparam logic [13:0] DegDiv = 14'd1571;
  localparam logic [23:0] DegRecip = 24'd10935626;
  localparam logic [12:0] DegMul = 13'd5625;
  localparam logic [19:0] DegBias = 20'd804352;

  localparam logic [7:0] RegRollOffset = 8'd0;
  localparam logic [7:0] RegPitchOffset = 8'd1;

  // arctangent of 2^-i in Q2.30 radians
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    begin
      case (idx)
        5'd0: v = 32'd843314857;
        5'd1: v = 32'd497837829;
        5'd2: v = 32'd263043837;
        5'd3: v = 32'd133525159;
        5'd4: v = 32'd67021687;
        5'd5: v = 32'd33543516;
        5'd6: v = 32'd16775851;
        5'd7: v = 32'd8388437;
        5'd8: v = 32'd4194283;
        5'd9: v = 32'd2097149;
        5'd10: v = 32'd1048576;
        5'd11: v = 32'd524288;
        5'd12: v = 32'd262144;
        5'd13: v = 32'd131072;
        5'd14: v = 32'd65536;
        5'd15: v = 32'd32768;
        5'd16: v = 32'd16384;
        5'd17: v = 32'd8192;
        5'd18: v = 32'd4096;
        5'd19: v = 32'd2048;
        5'd20: v = 32'd1024;
        5'd21: v = 32'd512;
        5'd22: v = 32'd256;
        5'd23: v = 32'd128;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/itkf_if.sv
// Channel interfaces: IMU sample input, tilt result output, register write.
`default_nettype none
interface itkf_sample_if;
  logic valid;
  logic ready;
  logic signed [15:0] gyro_x_sample;
  logic signed [15:0] gyro_y_sample;
  logic signed [15:0] accel_x_sample;
  logic signed [15:0] accel_y_sample;
  logic signed [15:0] accel_z_sample;
  modport source (output valid, gyro_x_sample, gyro_y_sample, accel_x_sample,
                  accel_y_sample, accel_z_sample, input ready);
  modport sink (input valid, gyro_x_sample, gyro_y_sample, accel_x_sample,
                accel_y_sample, accel_z_sample, output ready);
endinterface

interface itkf_result_if;
  logic valid;
  logic ready;
  logic signed [15:0] roll_out;
  logic signed [15:0] pitch_out;
  modport source (output valid, roll_out, pitch_out, input ready);
  modport sink (input valid, roll_out, pitch_out, output ready);
endinterface

interface itkf_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/imu_tilt_kalman_fusion_unit.sv
// Top level: roll and pitch tilt estimation with two 1D Kalman filters.
// Each axis runs 24 square-root steps, the CORDIC steps and a bit-serial gain division,
// with quotients from the reciprocal multiply corrected in ST_RFIX, all on one shared
// multiplier and divider. A new sample is taken only in ST_IDLE, after the last one has
// been through both axes; the unit waits in ST_FIN while an earlier result is held.
// Reset (rst, synchronous): offsets and estimates to zero, variances to VarReset.
`default_nettype none
module imu_tilt_kalman_fusion_unit #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input wire logic clk,
  input wire logic rst,
  itkf_sample_if.sink sample,
  itkf_result_if.source result,
  itkf_cfg_if.sink cfg
);

  localparam int unsigned IterCap = (CORDIC_ITERATIONS < itkf_pkg::AtanSteps) ?
                                    CORDIC_ITERATIONS : itkf_pkg::AtanSteps;
  localparam logic [4:0] IterLast = 5'(IterCap - 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQB, ST_SQC, ST_SQRT, ST_CORDIC, ST_ZMUL, ST_RCP, ST_RBACK, ST_RFIX,
    ST_ZDONE, ST_STEP, ST_STEPDONE, ST_GAIN, ST_MULLO, ST_MULHI, ST_UPD, ST_DIV, ST_FIN
  } state_t;

  state_t state, ret;
  logic ch;
  logic signed [15:0] gx, gy, ax, ay, az;
  logic signed [15:0] roll_off, pitch_off;
  logic signed [31:0] roll_est, pitch_est;
  logic [31:0] roll_var, pitch_var;
  logic [63:0] acc;
  logic [47:0] sq_rem, sq_root, sq_bit;
  logic [4:0] cnt;
  logic signed [27:0] cx, cy;
  logic signed [32:0] cz;
  logic signed [33:0] meas;
  logic signed [31:0] e_r;
  logic [31:0] p_r;
  logic [30:0] k_r;
  logic [33:0] dmag;
  logic dsign;
  logic [63:0] dnum;
  logic [32:0] drem, dden;
  logic [5:0] dcnt;
  logic [33:0] cnum, crem;
  logic [13:0] cdiv;
  logic [23:0] crec, cq;
  logic res_valid;
  logic signed [15:0] roll_q, pitch_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic signed [15:0] a_sel, b_sel, g_sel, off_sel;
  logic signed [31:0] est_sel;
  logic [31:0] var_sel;
  logic [15:0] b_mag, c_mag;
  logic [32:0] z_mag;
  logic signed [16:0] rate_d;
  logic [16:0] rate_mag;
  logic [33:0] div_t;
  logic div_ge;
  logic [47:0] sq_try;
  logic [32:0] step_q;
  logic signed [34:0] step_s, e_sum, upd_sum;
  logic signed [31:0] e_new, est_new;
  logic [32:0] p_sum;
  logic [31:0] p_new;
  logic [32:0] den_new;
  logic signed [33:0] diff;
  logic [63:0] rs_sum, var_sum;
  logic [33:0] rs;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -35'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] to_out(input logic signed [31:0] est);
    logic [32:0] mag;
    logic [24:0] q;
    begin
      mag = est[31] ? 33'(-{est[31], est}) : {1'b0, est};
      q = 25'((mag + 33'd128) >> 8);
      if (est[31]) return (q > 25'd32768) ? 16'sh8000 : 16'(-q);
      return (q > 25'd32767) ? 16'sh7FFF : q[15:0];
    end
  endfunction

  assign a_sel = ch ? ax : ay;
  assign b_sel = ch ? ay : ax;
  assign g_sel = ch ? gy : gx;
  assign off_sel = ch ? pitch_off : roll_off;
  assign est_sel = ch ? pitch_est : roll_est;
  assign var_sel = ch ? pitch_var : roll_var;

  assign b_mag = b_sel[15] ? 16'(-b_sel) : b_sel;
  assign c_mag = az[15] ? 16'(-az) : az;
  assign z_mag = cz[32] ? 33'(-cz) : cz;
  assign rate_d = 17'(g_sel) - 17'(off_sel);
  assign rate_mag = rate_d[16] ? 17'(-rate_d) : rate_d;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQB: begin mul_a = {16'd0, b_mag}; mul_b = {16'd0, b_mag}; end
      ST_SQC: begin mul_a = {16'd0, c_mag}; mul_b = {16'd0, c_mag}; end
      ST_ZMUL: begin mul_a = z_mag[31:0]; mul_b = {19'd0, itkf_pkg::DegMul}; end
      ST_RCP: begin mul_a = cnum[33:2]; mul_b = {8'd0, crec}; end
      ST_RBACK: begin mul_a = {8'd0, cq}; mul_b = {18'd0, cdiv}; end
      ST_MULLO: begin mul_a = {1'b0, k_r}; mul_b = dmag[31:0]; end
      ST_MULHI: begin mul_a = {1'b0, k_r}; mul_b = {30'd0, dmag[33:32]}; end
      ST_UPD: begin mul_a = 32'((32'd1 << 30) - {1'b0, k_r}); mul_b = p_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign div_t = {drem, dnum[63]};
  assign div_ge = div_t >= {1'b0, dden};
  assign sq_try = sq_root + sq_bit;

  assign step_q = {9'd0, cq};
  assign step_s = dsign ? -35'(step_q) : 35'(step_q);
  assign e_sum = 35'(est_sel) + step_s;
  assign e_new = sat32(e_sum);
  assign p_sum = 33'(var_sel) + 33'(itkf_pkg::ProcVar);
  assign p_new = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
  assign den_new = 33'(p_new) + itkf_pkg::MeasVar;
  assign diff = meas - 34'(e_r);
  assign rs_sum = acc + (64'd1 << 29);
  assign rs = rs_sum[63:30];
  assign upd_sum = dsign ? 35'(e_r) - 35'(rs) : 35'(e_r) + 35'(rs);
  assign est_new = sat32(upd_sum);
  assign var_sum = mul_p + (64'd1 << 29);

  assign sample.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign result.valid = res_valid;
  assign result.roll_out = roll_q;
  assign result.pitch_out = pitch_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret <= ST_IDLE;
      ch <= 1'b0;
      roll_off <= '0;
      pitch_off <= '0;
      roll_est <= '0;
      pitch_est <= '0;
      roll_var <= itkf_pkg::VarReset;
      pitch_var <= itkf_pkg::VarReset;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          itkf_pkg::RegRollOffset: roll_off <= cfg.data;
          itkf_pkg::RegPitchOffset: pitch_off <= cfg.data;
          default: ;
        endcase
      end
      if (state == ST_FIN && (!res_valid || result.ready)) res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            gx <= sample.gyro_x_sample;
            gy <= sample.gyro_y_sample;
            ax <= sample.accel_x_sample;
            ay <= sample.accel_y_sample;
            az <= sample.accel_z_sample;
            ch <= 1'b0;
            state <= ST_SQB;
          end
        end
        ST_SQB: begin
          acc <= mul_p;
          state <= ST_SQC;
        end
        ST_SQC: begin
          sq_rem <= {acc[31:0] + mul_p[31:0], 16'd0};
          sq_root <= '0;
          sq_bit <= 48'd1 << 46;
          cnt <= '0;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_rem >= sq_try) begin
            sq_rem <= sq_rem - sq_try;
            sq_root <= (sq_root >> 1) + sq_bit;
          end else begin
            sq_root <= sq_root >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (cnt == 5'(itkf_pkg::SqrtSteps - 1)) begin
            cnt <= '0;
            state <= ST_CORDIC;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_CORDIC: begin
          if (cnt == 5'd0 && a_sel == 16'sd0 && sq_root == 48'd0) begin
            // zero vector reads as level
            meas <= '0;
            state <= ST_STEP;
          end else begin
            logic signed [27:0] x0, y0, xsh, ysh;
            x0 = (cnt == 5'd0) ? 28'(sq_root[24:0]) : cx;
            y0 = (cnt == 5'd0) ? 28'(a_sel) <<< 8 : cy;
            xsh = x0 >>> cnt;
            ysh = y0 >>> cnt;
            if (!y0[27]) begin
              cx <= x0 + ysh;
              cy <= y0 - xsh;
              cz <= ((cnt == 5'd0) ? 33'sd0 : cz) + 33'(itkf_pkg::atan_q30(cnt));
            end else begin
              cx <= x0 - ysh;
              cy <= y0 + xsh;
              cz <= ((cnt == 5'd0) ? 33'sd0 : cz) - 33'(itkf_pkg::atan_q30(cnt));
            end
            cnt <= cnt + 5'd1;
            if (cnt == IterLast) state <= ST_ZMUL;
          end
        end
        ST_ZMUL: begin
          dsign <= cz[32];
          cnum <= 34'((mul_p + 64'(itkf_pkg::DegBias)) >> 10);
          cdiv <= itkf_pkg::DegDiv;
          crec <= itkf_pkg::DegRecip;
          ret <= ST_ZDONE;
          state <= ST_RCP;
        end
        // reciprocal estimate falls short by at most two, fixed up in ST_RFIX
        ST_RCP: begin
          cq <= mul_p[55:32];
          state <= ST_RBACK;
        end
        ST_RBACK: begin
          crem <= cnum - mul_p[33:0];
          state <= ST_RFIX;
        end
        ST_RFIX: begin
          if (crem >= {20'd0, cdiv}) begin
            crem <= crem - {20'd0, cdiv};
            cq <= cq + 24'd1;
          end else begin
            state <= ret;
          end
        end
        ST_ZDONE: begin
          meas <= dsign ? -34'(cq) : 34'(cq);
          state <= ST_STEP;
        end
        ST_STEP: begin
          dsign <= rate_d[16];
          cnum <= {2'd0, rate_mag, 15'd0} + itkf_pkg::RateBias;
          cdiv <= itkf_pkg::RateDiv;
          crec <= itkf_pkg::RateRecip;
          ret <= ST_STEPDONE;
          state <= ST_RCP;
        end
        ST_STEPDONE: begin
          e_r <= e_new;
          p_r <= p_new;
          dnum <= {2'd0, p_new, 30'd0} + 64'(den_new[32:1]);
          dden <= den_new;
          drem <= '0;
          dcnt <= '0;
          ret <= ST_GAIN;
          state <= ST_DIV;
        end
        ST_GAIN: begin
          k_r <= dnum[30:0];
          dsign <= diff[33];
          dmag <= diff[33] ? 34'(-diff) : diff;
          state <= ST_MULLO;
        end
        ST_MULLO: begin
          acc <= mul_p;
          state <= ST_MULHI;
        end
        ST_MULHI: begin
          // high partial product lands on top of the low one
          acc <= acc + {mul_p[31:0], 32'd0};
          state <= ST_UPD;
        end
        ST_DIV: begin
          dnum <= {dnum[62:0], div_ge};
          drem <= div_ge ? 33'(div_t - {1'b0, dden}) : div_t[32:0];
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd63) state <= ret;
        end
        ST_UPD: begin
          if (ch) begin
            pitch_est <= est_new;
            pitch_var <= var_sum[61:30];
            state <= ST_FIN;
          end else begin
            roll_est <= est_new;
            roll_var <= var_sum[61:30];
            ch <= 1'b1;
            state <= ST_SQB;
          end
        end
        ST_FIN: begin
          if (!res_valid || result.ready) begin
            roll_q <= to_out(roll_est);
            pitch_q <= to_out(pitch_est);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> state == ST_SQB && !ch)
    else $error("sample transaction did not start the roll pass");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_CORDIC |-> cnt <= IterLast)
    else $error("CORDIC ran past its iteration count");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> drem < dden)
    else $error("divider remainder out of range");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && (!res_valid || result.ready) |=> res_valid && state == ST_IDLE)
    else $error("result not loaded at end of sample");

endmodule
`default_nettype wire

// File: verif/tb_imu_tilt_kalman_fusion_unit.sv
// Self-checking testbench for the IMU tilt Kalman fusion unit.
`timescale 1ns / 1ps
module tb_imu_tilt_kalman_fusion_unit;

  localparam int unsigned CordicIters = 16;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 600;
  localparam int unsigned RandomItems = 1520;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } tilt_t;

  logic clk = 1'b0;
  logic rst;

  itkf_sample_if sample_ch ();
  itkf_result_if result_ch ();
  itkf_cfg_if cfg_ch ();

  imu_tilt_kalman_fusion_unit #(
    .CORDIC_ITERATIONS(CordicIters)
  ) uut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  // model state
  logic signed [15:0] roll_offset;
  logic signed [15:0] pitch_offset;
  logic signed [31:0] roll_est;
  logic [31:0] roll_var;
  logic signed [31:0] pitch_est;
  logic [31:0] pitch_var;

  tilt_t tilt_queue[$];
  int errors;
  int idle_cycles;

  longint atan_tbl[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint div_nearest(longint n, longint d);
    bit [63:0] mag;
    bit [63:0] q;
    mag = (n < 0) ? 64'(-n) : 64'(n);
    q = (mag + 64'(d / 2)) / 64'(d);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint shift_nearest(longint v, int s);
    bit [63:0] mag;
    bit [63:0] q;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    q = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan2(a, sqrt(b^2 + c^2)) in Q16.16 degrees
  function automatic longint accel_tilt(int a, int b, int c);
    bit [63:0] sq;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    sq = 64'(longint'(b) * b) + 64'(longint'(c) * c);
    x = longint'(int_sqrt(sq << 16));
    y = longint'(a) * 256;
    z = 0;
    if (a == 0 && x == 0) return 0;
    for (int i = 0; i < CordicIters && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_tbl[i];
      end else begin
        x -= ys; y += xs; z -= atan_tbl[i];
      end
    end
    return div_nearest(z * 90000, 25739264);
  endfunction

  task automatic filter_axis(inout logic signed [31:0] est, inout logic [31:0] var_q,
                             input longint step, input longint meas);
    logic signed [31:0] e;
    bit [63:0] p;
    bit [63:0] k;
    bit [63:0] mv;
    mv = 64'd150994944;
    e = clamp32(longint'(est) + step);
    p = 64'(var_q) + 64'd4295;
    if (p > 64'hffff_ffff) p = 64'hffff_ffff;
    k = ((p << 30) + ((p + mv) >> 1)) / (p + mv);
    est = clamp32(longint'(e) + shift_nearest((meas - longint'(e)) * longint'(k), 30));
    var_q = 32'((((64'd1 << 30) - k) * p + (64'd1 << 29)) >> 30);
  endtask

  function automatic logic signed [15:0] to_centi(logic signed [31:0] est);
    longint v;
    v = shift_nearest(longint'(est), 8);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic predict_tilt(int gx, int gy, int ax, int ay, int az);
    tilt_t t;
    filter_axis(roll_est, roll_var,
                div_nearest(longint'(gx - int'(roll_offset)) * 262144, 131000),
                accel_tilt(ay, ax, az));
    filter_axis(pitch_est, pitch_var,
                div_nearest(longint'(gy - int'(pitch_offset)) * 262144, 131000),
                accel_tilt(ax, ay, az));
    t.roll = to_centi(roll_est);
    t.pitch = to_centi(pitch_est);
    tilt_queue.push_back(t);
  endtask

  task automatic send_sample(int gx, int gy, int ax, int ay, int az);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.gyro_x_sample <= gx[15:0];
    sample_ch.gyro_y_sample <= gy[15:0];
    sample_ch.accel_x_sample <= ax[15:0];
    sample_ch.accel_y_sample <= ay[15:0];
    sample_ch.accel_z_sample <= az[15:0];
    do @(posedge clk); while (!sample_ch.ready);
    // predict from the 16-bit values that were actually driven
    predict_tilt(int'($signed(gx[15:0])), int'($signed(gy[15:0])),
                 int'($signed(ax[15:0])), int'($signed(ay[15:0])),
                 int'($signed(az[15:0])));
  endtask

  task automatic end_samples();
    sample_ch.valid <= 1'b0;
    wait (tilt_queue.size() == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == itkf_pkg::RegRollOffset) roll_offset = val;
    else if (idx == itkf_pkg::RegPitchOffset) pitch_offset = val;
  endtask

  task automatic set_offsets(logic [15:0] roll_val, logic [15:0] pitch_val);
    write_reg(itkf_pkg::RegRollOffset, roll_val);
    write_reg(itkf_pkg::RegPitchOffset, pitch_val);
  endtask

  function automatic int rand16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // accel axes each within +/-16384, gyro near its bias
  task automatic send_level_sample();
    int g;
    g = 16384;
    send_sample(int'(roll_offset) + int'($urandom_range(0, 400)) - 200,
                int'(pitch_offset) + int'($urandom_range(0, 400)) - 200,
                int'($urandom_range(0, 2 * g)) - g,
                int'($urandom_range(0, 2 * g)) - g,
                int'($urandom_range(0, 2 * g)) - g);
  endtask

  task automatic send_random_mix(int count, bit drain_often);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7) send_level_sample();
      else send_sample(rand16(), rand16(), rand16(), rand16(), rand16());
      if (drain_often && $urandom_range(0, 19) == 0) begin
        sample_ch.valid <= 1'b0;
        wait (tilt_queue.size() == 0);
        @(posedge clk);
      end
    end
  endtask

  task automatic test_directed();
    send_sample(0, 0, 0, 0, 0);                    // zero vector on both axes
    send_sample(0, 0, 0, 0, 16384);
    send_sample(0, 0, 0, 16384, 0);                // roll vertical
    send_sample(0, 0, -16384, 0, 0);               // pitch vertical
    send_sample(0, 0, 0, -32768, 0);
    send_sample(32767, 32767, 32767, 32767, 32767);
    send_sample(-32768, -32768, -32768, -32768, -32768);
    send_sample(32767, -32768, 32767, -32768, 0);
    send_sample(-32768, 32767, 0, 0, -32768);
    send_sample(1, -1, 1, -1, 1);
    for (int n = 0; n < 8; n++) send_sample(32767, 32767, 0, 0, 0);
    for (int n = 0; n < 6; n++) send_sample(-32768, -32768, 0, 0, 0);
    end_samples();
  endtask

  task automatic test_offset_extremes();
    set_offsets(16'sh7fff, 16'sh8000);
    send_sample(-32768, 32767, 0, 0, 16384);
    send_sample(32767, -32768, 100, -100, 16000);
    send_random_mix(300, 1'b0);
    end_samples();
    set_offsets(16'sh8000, 16'sh7fff);
    send_sample(32767, -32768, 0, 0, 16384);
    send_random_mix(300, 1'b0);
    end_samples();
  endtask

  task automatic test_ignored_index();
    for (int n = 0; n < 4; n++) begin
      write_reg(8'($urandom_range(2, 255)), 16'($urandom));
    end
    write_reg(8'hff, 16'h1234);
    send_random_mix(20, 1'b0);
    end_samples();
  endtask

  task automatic test_random_offsets();
    for (int ph = 0; ph < 3; ph++) begin
      set_offsets(16'($urandom), 16'($urandom));
      send_random_mix(RandomItems / 6, ph == 1);
      end_samples();
    end
    set_offsets(16'sd0, 16'sd0);
    send_random_mix(RandomItems - 3 * (RandomItems / 6) - 640, 1'b1);
    end_samples();
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // result side: random stalls, compare against oldest prediction
  initial begin
    tilt_t want;
    int stall;
    result_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
      if (tilt_queue.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        errors++;
      end else begin
        want = tilt_queue.pop_front();
        if (result_ch.roll_out !== want.roll)
          report_mismatch("roll_out", result_ch.roll_out, want.roll);
        if (result_ch.pitch_out !== want.pitch)
          report_mismatch("pitch_out", result_ch.pitch_out, want.pitch);
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.gyro_x_sample = '0;
    sample_ch.gyro_y_sample = '0;
    sample_ch.accel_x_sample = '0;
    sample_ch.accel_y_sample = '0;
    sample_ch.accel_z_sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    roll_offset = '0;
    pitch_offset = '0;
    roll_est = '0;
    pitch_est = '0;
    roll_var = 32'h0400_0000;
    pitch_var = 32'h0400_0000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_offset_extremes();
    test_ignored_index();
    test_random_offsets();

    wait (tilt_queue.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
